[hdl/assert_macros.svh]
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Flag a condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

[hdl/fmba_pkg.sv]
// Types, codes and defaults of the fit mode block allocator.
package fmba_pkg;

  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int OFFSET_BITS_DEF  = 20;
  localparam int HEADER_BYTES_DEF = 32;

  localparam int REQ_W  = 20;
  localparam int OFF_W  = 20;
  localparam int LEN_W  = 21;
  localparam int RS_W   = 21;
  localparam int MODE_W = 2;
  localparam int STAT_W = 2;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [RS_W-1:0] REGION_RST = RS_W'(1048576);

  typedef logic [MODE_W-1:0] gap_policy_t;
  localparam gap_policy_t FIT_FIRST = 2'd0;
  localparam gap_policy_t FIT_BEST  = 2'd1;
  localparam gap_policy_t FIT_WORST = 2'd2;

  typedef logic [STAT_W-1:0] status_t;
  localparam status_t ST_DONE    = 2'd0;
  localparam status_t ST_NOSPACE = 2'd1;
  localparam status_t ST_IGNORED = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic REG_POLICY      = 1'b0;
  localparam logic REG_REGION_SIZE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_AEND,
    S_SHIFT,
    S_COMMIT,
    S_RESP
  } fsm_state_t;

endpackage

[hdl/fmba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fmba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/fit_mode_block_allocator_top.sv]
// Top level of the fit mode block allocator: sequencer, block table RAM, register port.
//
//   port group   direction   handshake             payload
//   in_*         in          in_valid / in_ready   req_type, request_size, free_offset
//   out_*        out         out_valid / out_ready status, data_offset, granted_length
//   APB          in / out    psel, penable, pready policy (0x0), region_size (0x4)
//
// One request at a time. An allocate walks the whole block table through the RAM read
// port, one entry per cycle; a free stops at its match. Then move the entries above the
// chosen slot by one place (one read and one write per cycle), then commit and answer.
// The walk and the moves share the one RAM read port. Reset clears the entry count and the
// registers; no clearing pass. A finished beat waits in the output register while the next
// request is accepted; a second result holds in S_RESP until out_ready takes the first.
`include "assert_macros.svh"

module fit_mode_block_allocator_top #(
  parameter int MAX_BLOCKS   = fmba_pkg::MAX_BLOCKS_DEF,
  parameter int OFFSET_BITS  = fmba_pkg::OFFSET_BITS_DEF,
  parameter int HEADER_BYTES = fmba_pkg::HEADER_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_req_type,
  input  logic [fmba_pkg::REQ_W-1:0]  in_request_size,
  input  logic [fmba_pkg::OFF_W-1:0]  in_free_offset,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fmba_pkg::STAT_W-1:0] out_status,
  output logic [fmba_pkg::OFF_W-1:0]  out_data_offset,
  output logic [fmba_pkg::LEN_W-1:0]  out_granted_length,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fmba_pkg::ADDR_W-1:0] paddr,
  input  logic [fmba_pkg::DATA_W-1:0] pwdata,
  output logic [fmba_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import fmba_pkg::*;

  // Table index and count widths.
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  // Offsets never pass min(2^OFFSET_BITS, region_size), so entries need EW bits.
  localparam int CAP_SH = (OFFSET_BITS < RS_W) ? OFFSET_BITS : RS_W;
  localparam int EW     = CAP_SH + 1;
  // Arithmetic width covers sums of two entry fields and request plus header.
  localparam int AW     = ((EW > REQ_W + 1) ? EW : REQ_W + 1) + 1;

  localparam logic [AW-1:0] HDR        = AW'(HEADER_BYTES);
  localparam logic [AW-1:0] REGION_CAP = AW'(1) << CAP_SH;
  localparam logic [CW-1:0] MAX_CNT    = CW'(MAX_BLOCKS);

  // ---------------------------------------------------------------- registers
  gap_policy_t        policy_r;
  logic [RS_W-1:0]    region_size_r;
  logic               cfg_wr;
  logic               cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r      <= FIT_FIRST;
      region_size_r <= REGION_RST;
    end else if (cfg_wr) begin
      if (cfg_idx == REG_POLICY) begin
        policy_r <= pwdata[MODE_W-1:0];
      end else begin
        region_size_r <= pwdata[RS_W-1:0];
      end
    end
  end

  assign prdata = (cfg_idx == REG_REGION_SIZE) ? DATA_W'(region_size_r) : DATA_W'(policy_r);

  // Effective region end: region size capped at the offset space.
  logic [AW-1:0] end_w;
  assign end_w = (AW'(region_size_r) < REGION_CAP) ? AW'(region_size_r) : REGION_CAP;

  // ---------------------------------------------------------------- block table
  // Each word holds {start, length}; only entries below the count are ever read.
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [2*EW-1:0]   ram_wdata;
  logic              ram_re;
  logic [IW-1:0]     ram_raddr;
  logic [2*EW-1:0]   ram_rdata;

  fmba_ram #(
    .WIDTH (2 * EW),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- sequencer state
  fsm_state_t        state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              scan_rv_r, scan_rv_nxt;
  logic              sh_pend_r, sh_pend_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              is_free_r, is_free_nxt;
  logic [AW-1:0]     need_r, need_nxt;
  logic [AW-1:0]     target_r, target_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [CW-1:0]     scan_idx_r, scan_idx_nxt;
  logic [CW-1:0]     proc_idx_r, proc_idx_nxt;
  logic [AW-1:0]     cur_r, cur_nxt;
  logic              found_r, found_nxt;
  logic [AW-1:0]     best_start_r, best_start_nxt;
  logic [AW-1:0]     best_len_r, best_len_nxt;
  logic [AW-1:0]     best_rem_r, best_rem_nxt;
  logic [CW-1:0]     best_pos_r, best_pos_nxt;
  logic [CW-1:0]     sh_left_r, sh_left_nxt;
  logic [CW-1:0]     sh_src_r, sh_src_nxt;
  logic [IW-1:0]     sh_dst_r, sh_dst_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [OFF_W-1:0]  res_off_r, res_off_nxt;
  logic [LEN_W-1:0]  res_len_r, res_len_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [OFF_W-1:0]  out_off_r, out_off_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;

  // ---------------------------------------------------------------- gap evaluation
  // Gap in front of the entry just read (or up to the region end in S_AEND).
  logic [AW-1:0] ent_start_w, ent_len_w, ent_end_w;
  logic [AW-1:0] lim_w, gap_w, rem_raw_w, rem_w, len_w;
  logic          gap_ok_w, absorb_w, take_w;

  assign ent_start_w = AW'(ram_rdata[2*EW-1:EW]);
  assign ent_len_w   = AW'(ram_rdata[EW-1:0]);
  assign ent_end_w   = ent_start_w + ent_len_w;

  always_comb begin
    if (state_r == S_AEND || !(ent_start_w < end_w)) begin
      lim_w = end_w;
    end else begin
      lim_w = ent_start_w;
    end
    gap_w     = lim_w - cur_r;
    gap_ok_w  = (lim_w > cur_r) && (gap_w >= need_r);
    rem_raw_w = gap_w - need_r;
    // A leftover too small for a header goes to the block.
    absorb_w  = (rem_raw_w != '0) && (rem_raw_w < HDR);
    rem_w     = absorb_w ? '0 : rem_raw_w;
    len_w     = absorb_w ? gap_w : need_r;
    case (policy_r)
      FIT_FIRST: take_w = gap_ok_w && !found_r;
      FIT_BEST:  take_w = gap_ok_w && (!found_r || rem_w < best_rem_r);
      FIT_WORST: take_w = gap_ok_w && (!found_r || rem_w > best_rem_r);
      default:   take_w = gap_ok_w && !found_r;
    endcase
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_rv_nxt    = 1'b0;
    sh_pend_nxt    = sh_pend_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    is_free_nxt    = is_free_r;
    need_nxt       = need_r;
    target_nxt     = target_r;
    off_nxt        = off_r;
    scan_idx_nxt   = scan_idx_r;
    proc_idx_nxt   = proc_idx_r;
    cur_nxt        = cur_r;
    found_nxt      = found_r;
    best_start_nxt = best_start_r;
    best_len_nxt   = best_len_r;
    best_rem_nxt   = best_rem_r;
    best_pos_nxt   = best_pos_r;
    sh_left_nxt    = sh_left_r;
    sh_src_nxt     = sh_src_r;
    sh_dst_nxt     = sh_dst_r;
    res_status_nxt = res_status_r;
    res_off_nxt    = res_off_r;
    res_len_nxt    = res_len_r;
    out_status_nxt = out_status_r;
    out_off_nxt    = out_off_r;
    out_len_nxt    = out_len_r;
    ram_we         = 1'b0;
    ram_waddr      = sh_dst_r;
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = scan_idx_r[IW-1:0];
    in_ready       = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          is_free_nxt  = (in_req_type == REQ_FREE);
          need_nxt     = AW'(in_request_size) + HDR;
          target_nxt   = AW'(in_free_offset) - HDR;
          off_nxt      = in_free_offset;
          scan_idx_nxt = '0;
          proc_idx_nxt = '0;
          cur_nxt      = '0;
          found_nxt    = 1'b0;
          best_rem_nxt = '0;
          sh_pend_nxt  = 1'b0;
          res_off_nxt  = '0;
          res_len_nxt  = '0;
          if (in_req_type == REQ_ALLOC && count_r >= MAX_CNT) begin
            res_status_nxt = ST_NOSPACE;
            state_nxt      = S_RESP;
          end else if (in_req_type == REQ_FREE && AW'(in_free_offset) < HDR) begin
            res_status_nxt = ST_IGNORED;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue one table read per cycle; the data is handled in the next cycle.
        if (scan_idx_r < count_r) begin
          ram_re       = 1'b1;
          ram_raddr    = scan_idx_r[IW-1:0];
          scan_idx_nxt = scan_idx_r + 1'b1;
          scan_rv_nxt  = 1'b1;
        end
        if (scan_rv_r) begin
          proc_idx_nxt = proc_idx_r + 1'b1;
          if (is_free_r) begin
            if (ent_start_w == target_r) begin
              // Close the hole: move the entries above it down by one.
              best_pos_nxt = proc_idx_r;
              best_len_nxt = ent_len_w;
              sh_left_nxt  = count_r - proc_idx_r - 1'b1;
              sh_src_nxt   = proc_idx_r + 1'b1;
              sh_pend_nxt  = 1'b0;
              scan_rv_nxt  = 1'b0;
              state_nxt    = S_SHIFT;
            end
          end else begin
            if (take_w) begin
              found_nxt      = 1'b1;
              best_start_nxt = cur_r;
              best_len_nxt   = len_w;
              best_rem_nxt   = rem_w;
              best_pos_nxt   = proc_idx_r;
            end
            if (ent_end_w > cur_r) begin
              cur_nxt = ent_end_w;
            end
          end
        end else if (proc_idx_r == count_r) begin
          if (is_free_r) begin
            res_status_nxt = ST_IGNORED;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_AEND;
          end
        end
      end

      S_AEND: begin
        // Last gap runs to the region end.
        if (take_w) begin
          found_nxt      = 1'b1;
          best_start_nxt = cur_r;
          best_len_nxt   = len_w;
          best_rem_nxt   = rem_w;
          best_pos_nxt   = count_r;
          sh_left_nxt    = '0;
        end else begin
          sh_left_nxt    = count_r - best_pos_r;
        end
        sh_src_nxt  = count_r - 1'b1;
        sh_pend_nxt = 1'b0;
        if (take_w || found_r) begin
          state_nxt = S_SHIFT;
        end else begin
          res_status_nxt = ST_NOSPACE;
          state_nxt      = S_RESP;
        end
      end

      S_SHIFT: begin
        // Read one entry, write it one place over in the next cycle.
        if (sh_pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = sh_dst_r;
          ram_wdata = ram_rdata;
        end
        if (sh_left_r != '0) begin
          ram_re      = 1'b1;
          ram_raddr   = sh_src_r[IW-1:0];
          sh_pend_nxt = 1'b1;
          sh_left_nxt = sh_left_r - 1'b1;
          if (is_free_r) begin
            sh_dst_nxt = IW'(sh_src_r - 1'b1);
            sh_src_nxt = sh_src_r + 1'b1;
          end else begin
            sh_dst_nxt = IW'(sh_src_r + 1'b1);
            sh_src_nxt = sh_src_r - 1'b1;
          end
        end else begin
          sh_pend_nxt = 1'b0;
          if (!sh_pend_r) begin
            state_nxt = S_COMMIT;
          end
        end
      end

      S_COMMIT: begin
        res_status_nxt = ST_DONE;
        res_len_nxt    = LEN_W'(best_len_r);
        if (is_free_r) begin
          count_nxt   = count_r - 1'b1;
          res_off_nxt = off_r;
        end else begin
          ram_we      = 1'b1;
          ram_waddr   = best_pos_r[IW-1:0];
          ram_wdata   = {best_start_r[EW-1:0], best_len_r[EW-1:0]};
          count_nxt   = count_r + 1'b1;
          res_off_nxt = OFF_W'(best_start_r + HDR);
        end
        state_nxt = S_RESP;
      end

      S_RESP: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_off_nxt    = res_off_r;
          out_len_nxt    = res_len_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      scan_rv_r   <= 1'b0;
      sh_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_rv_r   <= scan_rv_nxt;
      sh_pend_r   <= sh_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_free_r    <= is_free_nxt;
    need_r       <= need_nxt;
    target_r     <= target_nxt;
    off_r        <= off_nxt;
    scan_idx_r   <= scan_idx_nxt;
    proc_idx_r   <= proc_idx_nxt;
    cur_r        <= cur_nxt;
    found_r      <= found_nxt;
    best_start_r <= best_start_nxt;
    best_len_r   <= best_len_nxt;
    best_rem_r   <= best_rem_nxt;
    best_pos_r   <= best_pos_nxt;
    sh_left_r    <= sh_left_nxt;
    sh_src_r     <= sh_src_nxt;
    sh_dst_r     <= sh_dst_nxt;
    res_status_r <= res_status_nxt;
    res_off_r    <= res_off_nxt;
    res_len_r    <= res_len_nxt;
    out_status_r <= out_status_nxt;
    out_off_r    <= out_off_nxt;
    out_len_r    <= out_len_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_data_offset    = out_off_r;
  assign out_granted_length = out_len_r;

  // ---------------------------------------------------------------- checks
  logic commit_w, insert_w, acc_w, fail_w, zero_w;

  assign commit_w = (state_r == S_COMMIT);
  assign insert_w = commit_w && !is_free_r;
  assign acc_w    = in_valid && in_ready;
  assign fail_w   = out_valid_r && (out_status_r != ST_DONE);
  assign zero_w   = (out_off_r == '0) && (out_len_r == '0);

  `ASSERT_NEVER(a_count_range, clk, rst_n, count_r > MAX_CNT, "entry count above table depth")
  `ASSERT_CLK(a_count_commit, clk, rst_n, !commit_w |=> count_r == $past(count_r), "count moved")
  `ASSERT_CLK(a_insert_room, clk, rst_n, insert_w |-> count_r < MAX_CNT, "insert when full")
  `ASSERT_CLK(a_accept_busy, clk, rst_n, acc_w |=> state_r != S_IDLE, "idle after accept")
  `ASSERT_CLK(a_fail_zero, clk, rst_n, fail_w |-> zero_w, "failed beat carries data")

endmodule

[tb/fit_mode_block_allocator_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the fit mode block allocator: directed and random requests.
//
// How the bench works:
// - A main initial block resets the block, then runs phases. Each phase writes the
//   registers over the register port while the block is idle, then fills a queue of
//   pending requests.
// - A driver at the falling edge pops requests onto the in_* channel. It inserts random
//   gaps: mostly none or short, a few long. Every third random phase runs with no gaps.
// - A monitor at the rising edge feeds each accepted request to a predictor that keeps
//   its own copy of the block table and the registers. The predictor queues one expected
//   grant per request. Each out_* beat is checked against the oldest expected grant.
// - out_ready stalls at random as well, so gaps land in the scan, in the shift and on a
//   waiting result.
module fit_mode_block_allocator_top_tb;
  import fmba_pkg::*;

  localparam int MAX_BLK = MAX_BLOCKS_DEF;
  localparam int HDR = HEADER_BYTES_DEF;
  localparam longint unsigned REGION_CAP = 64'd1 << OFFSET_BITS_DEF;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int NUM_PHASES = 8;
  // Code 3 is not a named mode; the block treats it as first fit.
  localparam gap_policy_t FIT_ALIAS = 2'd3;

  typedef struct packed {
    logic             kind;
    logic [REQ_W-1:0] size;
    logic [OFF_W-1:0] offset;
  } alloc_req_t;

  typedef struct packed {
    status_t          status;
    logic [OFF_W-1:0] data_offset;
    logic [LEN_W-1:0] length;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_req_type = REQ_ALLOC;
  logic [REQ_W-1:0] in_request_size = '0;
  logic [OFF_W-1:0] in_free_offset = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [OFF_W-1:0] out_data_offset;
  logic [LEN_W-1:0] out_granted_length;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  fit_mode_block_allocator_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_request_size   (in_request_size),
    .in_free_offset    (in_free_offset),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_data_offset   (out_data_offset),
    .out_granted_length(out_granted_length),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // Predictor copy of the block table and registers.
  logic [OFF_W-1:0] tbl_start [MAX_BLK];
  logic [LEN_W-1:0] tbl_len [MAX_BLK];
  int tbl_used = 0;
  gap_policy_t cur_fit = FIT_FIRST;
  logic [RS_W-1:0] cur_region = REGION_RST;

  alloc_req_t pending_reqs [$];
  grant_t grant_queue [$];
  int err_count = 0;
  int cycle_count = 0;
  bit in_beat_done = 1'b0;
  bit no_idle = 1'b0;
  int in_gap = 0;
  int out_stall = 0;

  // Random phase plan: fit mode, region, length, share of allocates, and whether
  // sizes come from a small set so that equal gaps (ties) show up.
  gap_policy_t ph_mode [NUM_PHASES] = '{FIT_FIRST, FIT_BEST, FIT_WORST, FIT_ALIAS,
                                        FIT_BEST, FIT_WORST, FIT_FIRST, FIT_WORST};
  int unsigned ph_region [NUM_PHASES] = '{1048576, 65536, 4096, 2097151,
                                          8192, 32, 300000, 1048576};
  int          ph_items [NUM_PHASES] = '{200, 200, 200, 200, 150, 30, 200, 200};
  int          ph_alloc_pct [NUM_PHASES] = '{85, 55, 55, 60, 55, 50, 50, 70};
  bit          ph_tie [NUM_PHASES] = '{0, 0, 0, 0, 1, 0, 0, 0};

  initial begin
    forever #5 clk = ~clk;
  end

  // Idle length: mostly zero, often short, a few long; zero throughout a quiet phase.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Allocate: scan gaps in address order, pick by fit mode, insert into the table.
  function automatic grant_t predict_alloc(input logic [REQ_W-1:0] req);
    longint unsigned need, top, cur, lim, gap, rem, len;
    longint unsigned pick_start, pick_len, pick_rem;
    int i, pick_pos;
    bit found, take;
    grant_t g;
    g = '0;
    g.status = ST_NOSPACE;
    if (tbl_used >= MAX_BLK) return g;
    need = req + HDR;
    top = (cur_region < REGION_CAP) ? cur_region : REGION_CAP;
    cur = 0;
    found = 1'b0;
    pick_start = 0;
    pick_len = 0;
    pick_rem = 0;
    pick_pos = 0;
    for (i = 0; i <= tbl_used; i++) begin
      // Blocks past the region end do not bound a gap; the region end does.
      lim = top;
      if (i < tbl_used && tbl_start[i] < top) lim = tbl_start[i];
      if (lim > cur && lim - cur >= need) begin
        gap = lim - cur;
        rem = gap - need;
        len = need;
        // Absorb a leftover too small to hold a header.
        if (rem > 0 && rem < HDR) begin
          rem = 0;
          len = gap;
        end
        case (cur_fit)
          FIT_BEST:  take = !found || rem < pick_rem;
          FIT_WORST: take = !found || rem > pick_rem;
          default:   take = !found;
        endcase
        if (take) begin
          found = 1'b1;
          pick_start = cur;
          pick_len = len;
          pick_rem = rem;
          pick_pos = i;
        end
      end
      if (i < tbl_used && tbl_start[i] + tbl_len[i] > cur) cur = tbl_start[i] + tbl_len[i];
    end
    if (!found) return g;
    for (i = tbl_used; i > pick_pos; i--) begin
      tbl_start[i] = tbl_start[i-1];
      tbl_len[i] = tbl_len[i-1];
    end
    tbl_start[pick_pos] = OFF_W'(pick_start);
    tbl_len[pick_pos] = LEN_W'(pick_len);
    tbl_used++;
    g.status = ST_DONE;
    g.data_offset = OFF_W'(pick_start + HDR);
    g.length = LEN_W'(pick_len);
    return g;
  endfunction

  // Free: drop the block whose data offset matches; anything else is ignored.
  function automatic grant_t predict_release(input logic [OFF_W-1:0] off);
    int i, j;
    grant_t g;
    g = '0;
    g.status = ST_IGNORED;
    if (off < HDR) return g;
    for (i = 0; i < tbl_used; i++) begin
      if (tbl_start[i] == off - HDR) begin
        g.status = ST_DONE;
        g.data_offset = off;
        g.length = tbl_len[i];
        for (j = i; j + 1 < tbl_used; j++) begin
          tbl_start[j] = tbl_start[j+1];
          tbl_len[j] = tbl_len[j+1];
        end
        tbl_used--;
        return g;
      end
    end
    return g;
  endfunction

  // Queue requests; fill the unused field with junk so its bits toggle too.
  function automatic void push_alloc(input logic [REQ_W-1:0] sz);
    alloc_req_t t;
    t.kind = REQ_ALLOC;
    t.size = sz;
    t.offset = OFF_W'($urandom());
    pending_reqs.insert(pending_reqs.size(), t);
  endfunction

  function automatic void push_free(input logic [OFF_W-1:0] off);
    alloc_req_t t;
    t.kind = REQ_FREE;
    t.size = REQ_W'($urandom());
    t.offset = off;
    pending_reqs.insert(pending_reqs.size(), t);
  endfunction

  // Register write: setup cycle, then access cycle until pready; update the local copy.
  task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * int'(idx));
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_POLICY) cur_fit = value[MODE_W-1:0];
    else cur_region = value[RS_W-1:0];
  endtask

  // Hold until every queued request went in and every expected grant came back.
  task automatic wait_idle();
    do @(posedge clk); while (pending_reqs.size() != 0 || in_valid || grant_queue.size() != 0);
  endtask

  // Request driver: advance on an accepted beat or an empty channel, never drop valid early.
  always @(negedge clk) begin : drive_req
    alloc_req_t beat;
    if (rst_n) begin
      if (!in_valid || in_beat_done) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          beat = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_req_type <= beat.kind;
          in_request_size <= beat.size;
          in_free_offset <= beat.offset;
          in_gap = idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result backpressure: random stall stretches on out_ready.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < 30) out_stall = idle_len();
      end
    end
  end

  // Monitor: predict on each accepted request beat, check each accepted result beat.
  always @(posedge clk) begin : watch
    grant_t want;
    grant_t got;
    in_beat_done <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      if (in_req_type == REQ_ALLOC) got = predict_alloc(in_request_size);
      else got = predict_release(in_free_offset);
      grant_queue.insert(grant_queue.size(), got);
    end
    if (rst_n && out_valid && out_ready) begin
      if (grant_queue.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("%0t: result beat with nothing expected: status %0d offset %0d length %0d",
                   $realtime, out_status, out_data_offset, out_granted_length);
      end else begin
        want = grant_queue.pop_front();
        if (out_status !== want.status || out_data_offset !== want.data_offset ||
            out_granted_length !== want.length) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: mismatch status %0d/%0d offset %0d/%0d length %0d/%0d (exp/got)",
                     $realtime, want.status, out_status, want.data_offset, out_data_offset,
                     want.length, out_granted_length);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : main
    int p, n, r, k;
    int unsigned span;
    logic [REQ_W-1:0] sz;
    logic [OFF_W-1:0] off;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, from the reset settings: first fit over the whole region.
    push_free(20'd0);            // below the header size
    push_free(20'd31);
    push_alloc(20'd0);           // header-only block at offset zero
    push_alloc(20'd100);
    push_alloc(20'd50);
    push_alloc(20'hFFFFF);       // larger than any gap
    push_free(20'd65);           // unknown offset
    push_free(20'd64);           // open a 132-byte hole
    push_alloc(20'd80);          // refill it, leftover of 20 absorbed
    push_alloc(20'd1048266);     // leave exactly one header of room at the top
    push_alloc(20'd0);           // lands at the top, data offset wraps to zero
    push_alloc(20'd0);           // nothing left
    push_free(20'd278);          // release the big block
    push_alloc(20'd968);
    push_alloc(20'd68);
    push_alloc(20'd468);
    push_alloc(20'd68);
    push_free(20'd278);          // holes of 1000 and 500 below the open top
    push_free(20'd1378);
    wait_idle();
    write_reg(REG_POLICY, DATA_W'(FIT_BEST));
    push_alloc(20'd168);         // best fit takes the 500 hole
    wait_idle();
    write_reg(REG_POLICY, DATA_W'(FIT_WORST));
    push_alloc(20'd168);         // worst fit takes the open top
    wait_idle();
    write_reg(REG_POLICY, DATA_W'(FIT_ALIAS));
    push_alloc(20'd268);         // behaves as first fit
    wait_idle();
    write_reg(REG_POLICY, DATA_W'(FIT_WORST));
    write_reg(REG_REGION_SIZE, 32'd2146);
    push_alloc(20'd668);         // only an exact fit exists
    wait_idle();
    write_reg(REG_REGION_SIZE, 32'd1000);
    push_alloc(20'd0);           // shrunk region, no gap below its end
    push_free(20'd1978);         // block past the region end is still freeable
    wait_idle();

    // Random phases: well-formed alloc/free traffic, with junk frees mixed in.
    for (p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_POLICY, DATA_W'(ph_mode[p]));
      write_reg(REG_REGION_SIZE, ph_region[p]);
      no_idle = (p % 3 == 2);
      span = (ph_region[p] < 1048576) ? ph_region[p] : 1048576;
      for (n = 0; n < ph_items[p]; n++) begin
        // Keep the queue short so frees pick from an up-to-date table.
        while (pending_reqs.size() >= 4) @(posedge clk);
        r = $urandom_range(0, 99);
        if (r < ph_alloc_pct[p]) begin
          r = $urandom_range(0, 99);
          sz = REQ_W'($urandom());
          if (ph_tie[p]) sz = REQ_W'(64 * $urandom_range(1, 4) - HDR);
          else if (r < 60) sz = REQ_W'($urandom_range(0, 64));
          else if (r < 85) sz = REQ_W'($urandom_range(0, span / 16));
          else if (r < 95) sz = REQ_W'($urandom_range(0, span - 1));
          push_alloc(sz);
        end else begin
          r = $urandom_range(0, 99);
          off = OFF_W'($urandom());
          if (tbl_used != 0 && r >= 10) begin
            if (r < 15) begin
              off = OFF_W'($urandom_range(0, HDR - 1));
            end else begin
              k = $urandom_range(0, tbl_used - 1);
              off = OFF_W'(tbl_start[k] + HDR);
              // Near miss: a few bytes past a real data offset.
              if (r < 25) off = off + OFF_W'($urandom_range(1, 3));
            end
          end
          push_free(off);
        end
      end
      wait_idle();
    end

    // Let any stray beat show up before judging.
    repeat (200) @(posedge clk);
    if (err_count == 0 && grant_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/fmba_pkg.sv
hdl/fmba_ram.sv
hdl/fit_mode_block_allocator_top.sv
tb/fit_mode_block_allocator_top_tb.sv
